FILE: rtl/bbfh_pkg.sv
// Shared types, command and status codes for the bounded back/forward history.
`default_nettype none
package bbfh_pkg;

   localparam int unsigned DEPTH_DEFAULT         = 16;
   localparam int unsigned PAYLOAD_WIDTH_DEFAULT = 64;

   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned PORT_PAY_W = 64;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned REV_W      = 32;
   localparam int unsigned TOTAL_W    = 5;

   localparam logic [FUNC_W-1:0] FUNC_VISIT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CURRENT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BACK    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FORWARD = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic exec;
      logic load;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/bounded_back_forward_history.sv
// Top level of the bounded back/forward navigation history.
//
// Request channel (req_*): one command per request, qualified by req_valid
// and taken when req_stall is low. Commands: visit, current, back, forward.
// Response channel (rsp_*): exactly one response per request, in order,
// taken when rsp_valid is high and rsp_stall is low.
// Each request passes through the controller states ST_IDLE and ST_LOAD:
// the accept cycle updates the cursor and counters and issues the ring
// memory write or read; ST_LOAD moves the registered read data into the
// response register once it is free. A new request is not taken until
// the previous one has been loaded. rsp_valid is registered and rises at
// the edge that loads the response register.
// A pending response waits in its register while rsp_stall is high; the
// next request may still be taken, and its response is held back until the
// register frees.
// Reset clears the history (count, cursor, oldest slot), the sequence
// counter to 0 and the revision to 1; ring contents are not cleared and are
// never read before being written.
`default_nettype none
module bounded_back_forward_history #(
   parameter int unsigned DEPTH         = bbfh_pkg::DEPTH_DEFAULT,
   parameter int unsigned PAYLOAD_WIDTH = bbfh_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bbfh_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [bbfh_pkg::PORT_PAY_W-1:0]   req_target_payload,
   input  wire logic                              req_target_has_location,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bbfh_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bbfh_pkg::PORT_PAY_W-1:0]        rsp_result_payload,
   output logic [bbfh_pkg::SEQ_W-1:0]             rsp_result_sequence,
   output logic [bbfh_pkg::TOTAL_W-1:0]           rsp_entry_total,
   output logic [bbfh_pkg::REV_W-1:0]             rsp_revision_value
);

   bbfh_pkg::cmd_type cmd;

   bbfh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bbfh_dp #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .req_func                (req_func),
      .req_target_payload      (req_target_payload),
      .req_target_has_location (req_target_has_location),
      .rsp_status              (rsp_status),
      .rsp_result_payload      (rsp_result_payload),
      .rsp_result_sequence     (rsp_result_sequence),
      .rsp_entry_total         (rsp_entry_total),
      .rsp_revision_value      (rsp_revision_value)
   );

endmodule
`default_nettype wire

FILE: rtl/bbfh_ctrl.sv
// Controller: request handshake, sequencing and result valid register.
`default_nettype none
module bbfh_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bbfh_pkg::cmd_type      cmd
);

   bbfh_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbfh_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.exec     = 1'b0;
      cmd.load     = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bbfh_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = bbfh_pkg::ST_LOAD;
            end
         end
         bbfh_pkg::ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bbfh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbfh_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/bbfh_dp.sv
// Datapath: history ring memory, cursor, counters and result registers.
`default_nettype none
module bbfh_dp #(
   parameter int unsigned DEPTH         = bbfh_pkg::DEPTH_DEFAULT,
   parameter int unsigned PAYLOAD_WIDTH = bbfh_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bbfh_pkg::cmd_type                 cmd,
   input  wire logic [bbfh_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [bbfh_pkg::PORT_PAY_W-1:0]   req_target_payload,
   input  wire logic                              req_target_has_location,
   output logic [bbfh_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bbfh_pkg::PORT_PAY_W-1:0]        rsp_result_payload,
   output logic [bbfh_pkg::SEQ_W-1:0]             rsp_result_sequence,
   output logic [bbfh_pkg::TOTAL_W-1:0]           rsp_entry_total,
   output logic [bbfh_pkg::REV_W-1:0]             rsp_revision_value
);

   localparam int unsigned IW     = $clog2(DEPTH);
   localparam int unsigned CW     = $clog2(DEPTH + 1);
   localparam int unsigned PortW  = bbfh_pkg::PORT_PAY_W;
   localparam int unsigned SeqW   = bbfh_pkg::SEQ_W;
   localparam int unsigned RevW   = bbfh_pkg::REV_W;
   localparam int unsigned TotalW = bbfh_pkg::TOTAL_W;

   function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   logic [PAYLOAD_WIDTH-1:0] mem_payload [DEPTH];
   logic [SeqW-1:0]          mem_sequence [DEPTH];

   logic [IW-1:0]   oldest_ff, oldest_in;
   logic [CW-1:0]   held_ff, held_in;
   logic [IW-1:0]   cursor_ff, cursor_in;
   logic [SeqW-1:0] seq_ff, seq_in;
   logic [RevW-1:0] rev_ff, rev_in;

   logic [bbfh_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                          pend_hit_ff, pend_hit_in;
   logic [PAYLOAD_WIDTH-1:0]      rd_payload_ff;
   logic [SeqW-1:0]               rd_sequence_ff;

   logic [bbfh_pkg::STATUS_W-1:0] status_ff;
   logic [PortW-1:0]              payload_ff;
   logic [SeqW-1:0]               sequence_ff;
   logic [TotalW-1:0]             total_ff;
   logic [RevW-1:0]               revision_ff;

   logic [CW-1:0]   cur_ext, cur_inc, held_trim, held_base;
   logic            full;
   logic [IW-1:0]   oldest_vis, wr_slot, rd_slot;
   logic            wr_en, rd_en;
   logic [CW+TotalW-1:0] held_wide;

   always_comb begin
      cur_ext    = CW'(cursor_ff);
      cur_inc    = cur_ext + CW'(1);
      held_trim  = (held_ff != '0 && cur_inc < held_ff) ? cur_inc : held_ff;
      full       = (held_trim == CW'(DEPTH));
      oldest_vis = full ? slot_add(oldest_ff, CW'(1)) : oldest_ff;
      held_base  = full ? CW'(DEPTH - 1) : held_trim;
      wr_slot    = slot_add(oldest_vis, held_base);
   end

   always_comb begin
      oldest_in      = oldest_ff;
      held_in        = held_ff;
      cursor_in      = cursor_ff;
      seq_in         = seq_ff;
      rev_in         = rev_ff;
      pend_status_in = pend_status_ff;
      pend_hit_in    = pend_hit_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_slot        = slot_add(oldest_ff, cur_ext);
      if (cmd.exec) begin
         pend_status_in = bbfh_pkg::STATUS_OK;
         pend_hit_in    = 1'b0;
         if (req_func == bbfh_pkg::FUNC_VISIT) begin
            if (!req_target_has_location) begin
               pend_status_in = bbfh_pkg::STATUS_INVALID;
            end else begin
               wr_en     = 1'b1;
               seq_in    = seq_ff + SeqW'(1);
               oldest_in = oldest_vis;
               held_in   = held_base + CW'(1);
               cursor_in = held_base[IW-1:0];
               rev_in    = rev_ff + RevW'(1);
            end
         end else if (held_ff == '0) begin
            pend_status_in = bbfh_pkg::STATUS_NOT_FOUND;
         end else begin
            case (req_func)
               bbfh_pkg::FUNC_CURRENT: begin
                  pend_hit_in = 1'b1;
                  rd_en       = 1'b1;
               end
               bbfh_pkg::FUNC_BACK: begin
                  if (cursor_ff == '0) begin
                     pend_status_in = bbfh_pkg::STATUS_NOT_FOUND;
                  end else begin
                     cursor_in   = cursor_ff - IW'(1);
                     rev_in      = rev_ff + RevW'(1);
                     rd_slot     = slot_add(oldest_ff, cur_ext - CW'(1));
                     pend_hit_in = 1'b1;
                     rd_en       = 1'b1;
                  end
               end
               bbfh_pkg::FUNC_FORWARD: begin
                  if (cur_inc >= held_ff) begin
                     pend_status_in = bbfh_pkg::STATUS_NOT_FOUND;
                  end else begin
                     cursor_in   = cur_inc[IW-1:0];
                     rev_in      = rev_ff + RevW'(1);
                     rd_slot     = slot_add(oldest_ff, cur_inc);
                     pend_hit_in = 1'b1;
                     rd_en       = 1'b1;
                  end
               end
               default: begin
                  pend_status_in = bbfh_pkg::STATUS_NOT_FOUND;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         held_ff   <= '0;
         cursor_ff <= '0;
         seq_ff    <= '0;
         rev_ff    <= RevW'(1);
      end else begin
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
         cursor_ff <= cursor_in;
         seq_ff    <= seq_in;
         rev_ff    <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_hit_ff    <= pend_hit_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_payload[wr_slot]  <= req_target_payload[PAYLOAD_WIDTH-1:0];
         mem_sequence[wr_slot] <= seq_in;
      end
      if (rd_en) begin
         rd_payload_ff  <= mem_payload[rd_slot];
         rd_sequence_ff <= mem_sequence[rd_slot];
      end
   end

   assign held_wide = (CW+TotalW)'(held_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff   <= pend_status_ff;
         payload_ff  <= pend_hit_ff ? PortW'(rd_payload_ff) : '0;
         sequence_ff <= pend_hit_ff ? rd_sequence_ff : '0;
         total_ff    <= held_wide[TotalW-1:0];
         revision_ff <= rev_ff;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_result_payload  = payload_ff;
   assign rsp_result_sequence = sequence_ff;
   assign rsp_entry_total     = total_ff;
   assign rsp_revision_value  = revision_ff;

endmodule
`default_nettype wire
